@@ design/bitset_word_operation_unit_assert.svh @@
// assertion macros for the bit-set word operation unit
`ifndef BITSET_WORD_OPERATION_UNIT_ASSERT_SVH
`define BITSET_WORD_OPERATION_UNIT_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define BWOU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a property in the next
`define BWOU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/bwou_pkg.sv @@
// types, operation codes and helper functions of the bit-set word operation unit
`default_nettype none

package bwou_pkg;

  localparam int DATA_W = 64;
  localparam int KIND_W = 5;
  localparam int AMT_W  = 7;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_XOR     = 5'd0;
  localparam logic [KIND_W-1:0] KIND_OR      = 5'd1;
  localparam logic [KIND_W-1:0] KIND_AND     = 5'd2;
  localparam logic [KIND_W-1:0] KIND_ANDNOT  = 5'd3;
  localparam logic [KIND_W-1:0] KIND_SHL     = 5'd4;
  localparam logic [KIND_W-1:0] KIND_SHR     = 5'd5;
  localparam logic [KIND_W-1:0] KIND_TEST    = 5'd6;
  localparam logic [KIND_W-1:0] KIND_SET     = 5'd7;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 5'd8;
  localparam logic [KIND_W-1:0] KIND_FLIP    = 5'd9;
  localparam logic [KIND_W-1:0] KIND_FILL    = 5'd10;
  localparam logic [KIND_W-1:0] KIND_COMPL   = 5'd11;
  localparam logic [KIND_W-1:0] KIND_TRUNC   = 5'd12;
  localparam logic [KIND_W-1:0] KIND_RANK    = 5'd13;
  localparam logic [KIND_W-1:0] KIND_PARITY  = 5'd14;
  localparam logic [KIND_W-1:0] KIND_FIRST   = 5'd15;
  localparam logic [KIND_W-1:0] KIND_LAST    = 5'd16;
  localparam logic [KIND_W-1:0] KIND_EXTRACT = 5'd17;
  localparam logic [KIND_W-1:0] KIND_DEPOSIT = 5'd18;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic [AMT_W-1:0]  amount;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_set;
    logic              flag;
    logic [CNT_W-1:0]  count;
    logic              range_error;
  } out_item_t;

  // population count as a tree of field sums
  function automatic logic [CNT_W-1:0] popcnt64(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] s;
    s = x - ((x >> 1) & 64'h5555_5555_5555_5555);
    s = (s & 64'h3333_3333_3333_3333) + ((s >> 2) & 64'h3333_3333_3333_3333);
    s = (s + (s >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
    s = s + (s >> 8);
    s = s + (s >> 16);
    s = s + (s >> 32);
    return s[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/bwou_prefix.sv @@
// prefix count of set mask bits below each position, log-depth adder network
`default_nettype none

module bwou_prefix (
  input  logic [bwou_pkg::DATA_W-1:0] mask,
  output logic [bwou_pkg::IDX_W-1:0]  ones_below [bwou_pkg::DATA_W]
);
  import bwou_pkg::*;

  localparam int STAGES = IDX_W;

  logic [CNT_W-1:0] sum [STAGES+1][DATA_W];

  // inclusive prefix sums, one doubling distance per stage
  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      sum[0][i] = CNT_W'(mask[i]);
    end
    for (int s = 0; s < STAGES; s++) begin
      for (int i = 0; i < DATA_W; i++) begin
        if (i >= (1 << s)) begin
          sum[s+1][i] = sum[s][i] + sum[s][i-(1<<s)];
        end else begin
          sum[s+1][i] = sum[s][i];
        end
      end
    end
  end

  // exclusive count: inclusive sum of the position below
  always_comb begin
    ones_below[0] = '0;
    for (int i = 1; i < DATA_W; i++) begin
      ones_below[i] = sum[STAGES][i-1][IDX_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ design/bwou_compress.sv @@
// bit extract under a mask: selected bits slide down through log-step shift stages
`default_nettype none

module bwou_compress (
  input  logic [bwou_pkg::DATA_W-1:0] data,
  input  logic [bwou_pkg::DATA_W-1:0] mask,
  input  logic [bwou_pkg::IDX_W-1:0]  ones_below [bwou_pkg::DATA_W],
  output logic [bwou_pkg::DATA_W-1:0] packed_set
);
  import bwou_pkg::*;

  localparam int STAGES = IDX_W;

  logic             v  [STAGES+1][DATA_W];
  logic [IDX_W-1:0] sh [STAGES+1][DATA_W];
  logic             keep;
  logic             move;

  // each selected bit moves down by the number of clear mask bits below it;
  // shift distances are monotone, so the stages never collide
  always_comb begin
    keep = 1'b0;
    move = 1'b0;
    for (int i = 0; i < DATA_W; i++) begin
      v[0][i]  = data[i] & mask[i];
      sh[0][i] = v[0][i] ? (IDX_W'(i) - ones_below[i]) : '0;
    end
    for (int s = 0; s < STAGES; s++) begin
      for (int p = 0; p < DATA_W; p++) begin
        keep = v[s][p] & ~sh[s][p][s];
        move = 1'b0;
        if (p + (1 << s) < DATA_W) begin
          move = v[s][p+(1<<s)] & sh[s][p+(1<<s)][s];
        end
        v[s+1][p]  = keep | move;
        sh[s+1][p] = keep ? sh[s][p] : '0;
        if (move) begin
          sh[s+1][p] = sh[s][p+(1<<s)];
        end
      end
    end
    for (int p = 0; p < DATA_W; p++) begin
      packed_set[p] = v[STAGES][p];
    end
  end

endmodule

`default_nettype wire

@@ design/bwou_core.sv @@
// operation datapath: decodes the kind and forms one result item
`default_nettype none

module bwou_core #(
  parameter int WIDTH = 64
) (
  input  bwou_pkg::in_item_t  item,
  output bwou_pkg::out_item_t res
);
  import bwou_pkg::*;

  logic [DATA_W-1:0] wmask;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] lm;
  logic [DATA_W-1:0] bit_sel;
  logic [DATA_W-1:0] smear;
  logic [DATA_W-1:0] dep_set;
  logic [DATA_W-1:0] ext_set;
  logic [IDX_W-1:0]  ones_below [DATA_W];
  logic [IDX_W-1:0]  sh_amt;
  logic              idx_ok;
  logic              lim_ok;
  logic [CNT_W-1:0]  pop_last;

  // width mask and limit mask
  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      wmask[i] = (i < WIDTH);
      lm[i]    = (CNT_W'(i) < item.amount) & (i < WIDTH);
    end
  end

  assign a       = item.operand_a & wmask;
  assign b       = item.operand_b & wmask;
  assign idx_ok  = item.amount < AMT_W'(WIDTH);
  assign lim_ok  = item.amount <= AMT_W'(WIDTH);
  assign sh_amt  = item.amount[IDX_W-1:0];
  assign bit_sel = idx_ok ? (DATA_W'(1) << sh_amt) : '0;

  // smear the top set bit downward for the last-bit search
  always_comb begin
    smear = a;
    for (int s = 0; s < IDX_W; s++) begin
      smear = smear | (smear >> (1 << s));
    end
  end

  assign pop_last = popcnt64(smear);

  // rank of each mask position feeds extract and deposit
  bwou_prefix u_prefix (
    .mask       (b),
    .ones_below (ones_below)
  );

  bwou_compress u_compress (
    .data       (a),
    .mask       (b),
    .ones_below (ones_below),
    .packed_set (ext_set)
  );

  // deposit: each mask position takes the source bit of its rank
  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      dep_set[i] = b[i] & a[ones_below[i]];
    end
  end

  // kind decode
  always_comb begin
    res = '0;
    unique case (item.kind)
      KIND_XOR:    res.result_set = a ^ b;
      KIND_OR:     res.result_set = a | b;
      KIND_AND:    res.result_set = a & b;
      KIND_ANDNOT: res.result_set = a & ~b;
      KIND_SHL:    res.result_set = idx_ok ? ((a << sh_amt) & wmask) : '0;
      KIND_SHR:    res.result_set = idx_ok ? (a >> sh_amt) : '0;
      KIND_TEST: begin
        res.range_error = ~idx_ok;
        res.flag        = idx_ok & a[sh_amt];
      end
      KIND_SET: begin
        res.range_error = ~idx_ok;
        res.result_set  = a | bit_sel;
      end
      KIND_CLEAR: begin
        res.range_error = ~idx_ok;
        res.result_set  = a & ~bit_sel;
      end
      KIND_FLIP: begin
        res.range_error = ~idx_ok;
        res.result_set  = a ^ bit_sel;
      end
      KIND_FILL: begin
        res.range_error = ~lim_ok;
        res.result_set  = lim_ok ? lm : a;
      end
      KIND_COMPL: begin
        res.range_error = ~lim_ok;
        res.result_set  = lim_ok ? (a ^ lm) : a;
      end
      KIND_TRUNC: begin
        res.range_error = ~lim_ok;
        res.result_set  = lim_ok ? (a & lm) : a;
      end
      KIND_RANK: begin
        res.range_error = ~lim_ok;
        res.count       = popcnt64(lim_ok ? (a & lm) : a);
      end
      KIND_PARITY:  res.flag = ^(a & b);
      // trailing zero count; an empty set counts every bit
      KIND_FIRST:   res.count = popcnt64(~a & (a - DATA_W'(1)) & wmask);
      KIND_LAST:    res.count = (a == '0) ? CNT_W'(WIDTH) : (pop_last - CNT_W'(1));
      KIND_EXTRACT: res.result_set = ext_set;
      KIND_DEPOSIT: res.result_set = dep_set;
      default:      res = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/bitset_word_operation_unit.sv @@
// top level: input register, operation datapath and result register
// an item moves from the input register through the datapath into the result register; a stall holds it there
// throughput: one item per cycle while out_ready is high; the input and result registers each hold one item
// ready stays high while the result register drains or a slot is free
// reset: synchronous active-low rst_n clears both valid flags, no payload reset
`default_nettype none

module bitset_word_operation_unit #(
  parameter int WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bwou_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bwou_pkg::out_item_t out_data
);
  import bwou_pkg::*;

  logic      in_v_r;
  logic      in_v_nxt;
  in_item_t  in_item_r;
  in_item_t  in_item_nxt;
  logic      out_v_r;
  logic      out_v_nxt;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  out_item_t core_res;
  logic      out_adv;

  // handshake control
  assign out_adv  = ~out_v_r | out_ready;
  assign in_ready = ~in_v_r | out_adv;

  always_comb begin
    in_v_nxt     = in_ready ? in_valid : in_v_r;
    in_item_nxt  = (in_valid & in_ready) ? in_data : in_item_r;
    out_v_nxt    = out_adv ? in_v_r : out_v_r;
    out_item_nxt = (out_adv & in_v_r) ? core_res : out_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    in_item_r  <= in_item_nxt;
    out_item_r <= out_item_nxt;
  end

  bwou_core #(
    .WIDTH (WIDTH)
  ) u_core (
    .item (in_item_r),
    .res  (core_res)
  );

  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

@@ design/bwou_checker.sv @@
// port-level checker for the bit-set word operation unit and its bind
`default_nettype none

`include "bitset_word_operation_unit_assert.svh"

module bwou_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bwou_pkg::out_item_t out_data
);
  import bwou_pkg::*;

  logic [1:0] pend_r;
  logic [1:0] pend_nxt;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;

  // items taken in but not yet delivered
  always_comb begin
    pend_nxt = pend_r + 2'(in_xfer) - 2'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `BWOU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed or dropped")
  `BWOU_ASSERT_ALWAYS(a_no_phantom, !out_valid || (pend_r != 2'd0), "result without a pending item")
  `BWOU_ASSERT_ALWAYS(a_ready_free, (pend_r == 2'd2) || in_ready, "not ready while a slot is free")
  `BWOU_ASSERT_ALWAYS(a_flag_alone, !(out_valid && out_data.flag) || ((out_data.count == '0) && !out_data.range_error), "flag with count or error")

endmodule

bind bitset_word_operation_unit bwou_checker u_bwou_checker (.*);

`default_nettype wire

@@ sim/bitset_word_operation_unit_check.sv @@
// predicts and checks the results of the bit-set word operation unit
`timescale 1ns / 100ps

module bitset_word_operation_unit_check
  import bwou_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        error_count,
  output int        pending,
  output int        results_seen
);

  // results owed by the block, oldest first
  out_item_t expected_results[$];

  initial begin
    error_count  = 0;
    pending      = 0;
    results_seen = 0;
  end

  // number of set bits, counted one at a time
  function automatic int unsigned count_ones(input logic [DATA_W-1:0] x);
    int unsigned n;
    n = 0;
    for (int i = 0; i < DATA_W; i++) begin
      n += x[i];
    end
    return n;
  endfunction

  // expected result of one word operation
  function automatic out_item_t predict_word_result(input in_item_t item);
    out_item_t         r;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] onehot;
    logic [DATA_W-1:0] below;
    logic              index_ok;
    logic              limit_ok;
    int unsigned       amt;
    int unsigned       k;
    r        = '0;
    a        = item.operand_a;
    b        = item.operand_b;
    amt      = item.amount;
    index_ok = (amt < DATA_W);
    limit_ok = (amt <= DATA_W);
    onehot   = index_ok ? (64'd1 << amt) : '0;
    below    = (amt >= DATA_W) ? '1 : ((64'd1 << amt) - 64'd1);
    k        = 0;
    case (item.kind)
      KIND_XOR:    r.result_set = a ^ b;
      KIND_OR:     r.result_set = a | b;
      KIND_AND:    r.result_set = a & b;
      KIND_ANDNOT: r.result_set = a & ~b;
      // long shifts empty the set
      KIND_SHL:    r.result_set = index_ok ? (a << amt) : '0;
      KIND_SHR:    r.result_set = index_ok ? (a >> amt) : '0;
      // single-bit access, a bad index leaves the set alone
      KIND_TEST: begin
        r.range_error = !index_ok;
        r.flag        = ((a & onehot) != '0);
      end
      KIND_SET: begin
        r.range_error = !index_ok;
        r.result_set  = a | onehot;
      end
      KIND_CLEAR: begin
        r.range_error = !index_ok;
        r.result_set  = a & ~onehot;
      end
      KIND_FLIP: begin
        r.range_error = !index_ok;
        r.result_set  = a ^ onehot;
      end
      // limit based, a bad limit returns a unchanged
      KIND_FILL: begin
        r.range_error = !limit_ok;
        r.result_set  = limit_ok ? below : a;
      end
      KIND_COMPL: begin
        r.range_error = !limit_ok;
        r.result_set  = limit_ok ? (a ^ below) : a;
      end
      KIND_TRUNC: begin
        r.range_error = !limit_ok;
        r.result_set  = limit_ok ? (a & below) : a;
      end
      KIND_RANK: begin
        r.range_error = !limit_ok;
        r.count       = CNT_W'(count_ones(limit_ok ? (a & below) : a));
      end
      KIND_PARITY: r.flag = 1'(count_ones(a & b) % 2);
      // searches give the width when the set is empty
      KIND_FIRST: begin
        r.count = CNT_W'(DATA_W);
        for (int i = DATA_W - 1; i >= 0; i--) begin
          if (a[i]) r.count = CNT_W'(i);
        end
      end
      KIND_LAST: begin
        r.count = CNT_W'(DATA_W);
        for (int i = 0; i < DATA_W; i++) begin
          if (a[i]) r.count = CNT_W'(i);
        end
      end
      // gather bits of a under the mask toward bit 0
      KIND_EXTRACT: begin
        for (int i = 0; i < DATA_W; i++) begin
          if (b[i]) begin
            r.result_set[k] = a[i];
            k++;
          end
        end
      end
      // scatter low bits of a to the mask positions
      KIND_DEPOSIT: begin
        for (int i = 0; i < DATA_W; i++) begin
          if (b[i]) begin
            r.result_set[i] = a[k];
            k++;
          end
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    error_count++;
  endtask

  // follow both channels at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_word_result(in_data));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, out_data);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_set !== want.result_set)
            report_mismatch("result_set", want.result_set, out_data.result_set);
          if (out_data.flag !== want.flag)
            report_mismatch("flag", DATA_W'(want.flag), DATA_W'(out_data.flag));
          if (out_data.count !== want.count)
            report_mismatch("count", DATA_W'(want.count), DATA_W'(out_data.count));
          if (out_data.range_error !== want.range_error)
            report_mismatch("range_error", DATA_W'(want.range_error),
                            DATA_W'(out_data.range_error));
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

@@ sim/tb_bitset_word_operation_unit.sv @@
// testbench top for the bit-set word operation unit: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_bitset_word_operation_unit;
  import bwou_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 300;

  localparam logic [DATA_W-1:0] ALL_ONES = '1;
  localparam logic [DATA_W-1:0] NO_BITS  = '0;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int error_count;
  int pending;
  int results_seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitset_word_operation_unit #(
    .WIDTH(DATA_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  bitset_word_operation_unit_check result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .error_count (error_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DATA_W-1:0] random_set();
    case ($urandom_range(0, 7))
      0:       return NO_BITS;
      1:       return ALL_ONES;
      2:       return 64'd1 << $urandom_range(0, DATA_W - 1);
      3:       return ~(64'd1 << $urandom_range(0, DATA_W - 1));
      4:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      5:       return {$urandom, $urandom} | {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // amounts cluster on the index and limit boundaries
  function automatic logic [AMT_W-1:0] random_amount();
    case ($urandom_range(0, 9))
      6:       return AMT_W'(DATA_W);
      7:       return AMT_W'(DATA_W + 1);
      8:       return AMT_W'(DATA_W - 1);
      9:       return AMT_W'($urandom_range(0, 127));
      default: return AMT_W'($urandom_range(0, DATA_W - 1));
    endcase
  endfunction

  // unused codes now and then
  function automatic logic [KIND_W-1:0] random_kind();
    if ($urandom_range(0, 15) == 0) return KIND_W'($urandom_range(19, 31));
    return KIND_W'($urandom_range(0, 18));
  endfunction

  // offer one item after a random idle stretch and wait for its transfer
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] a,
                           input logic [DATA_W-1:0] b, input logic [AMT_W-1:0] amt);
    int       gap;
    in_item_t item;
    gap            = pick_gap();
    item.kind      = kind;
    item.operand_a = a;
    item.operand_b = b;
    item.amount    = amt;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: runs of ready, random stalls and one long hold-off
  initial begin : receiver
    int  run;
    int  gap;
    bit  hold_done;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && results_seen >= 300) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_done = 1'b1;
      end
      run = $urandom_range(1, 40);
      repeat (run) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      gap = pick_gap();
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: every operation, field extremes and boundary cases
    send_item(KIND_XOR, ALL_ONES, NO_BITS, 7'd0);
    send_item(KIND_OR, NO_BITS, ALL_ONES, 7'd127);
    send_item(KIND_AND, ALL_ONES, ALL_ONES, 7'd0);
    send_item(KIND_ANDNOT, ALL_ONES, 64'h0123_4567_89ab_cdef, 7'd5);
    send_item(KIND_SHL, ALL_ONES, NO_BITS, 7'd0);
    send_item(KIND_SHL, ALL_ONES, NO_BITS, 7'd64);
    send_item(KIND_SHR, ALL_ONES, NO_BITS, 7'd127);
    send_item(KIND_SHR, ALL_ONES, NO_BITS, 7'd63);
    send_item(KIND_TEST, 64'h8000_0000_0000_0000, NO_BITS, 7'd63);
    send_item(KIND_TEST, ALL_ONES, NO_BITS, 7'd64);
    send_item(KIND_SET, NO_BITS, NO_BITS, 7'd0);
    send_item(KIND_CLEAR, ALL_ONES, NO_BITS, 7'd127);
    send_item(KIND_FLIP, NO_BITS, NO_BITS, 7'd63);
    send_item(KIND_FILL, NO_BITS, NO_BITS, 7'd64);
    send_item(KIND_FILL, 64'h5555_5555_5555_5555, NO_BITS, 7'd65);
    send_item(KIND_COMPL, ALL_ONES, NO_BITS, 7'd0);
    send_item(KIND_TRUNC, ALL_ONES, NO_BITS, 7'd127);
    send_item(KIND_RANK, ALL_ONES, NO_BITS, 7'd64);
    send_item(KIND_RANK, ALL_ONES, NO_BITS, 7'd100);
    send_item(KIND_PARITY, ALL_ONES, 64'h0000_0000_0000_0007, 7'd0);
    send_item(KIND_FIRST, NO_BITS, NO_BITS, 7'd0);
    send_item(KIND_LAST, NO_BITS, NO_BITS, 7'd0);
    send_item(KIND_FIRST, 64'h8000_0000_0000_0000, NO_BITS, 7'd0);
    send_item(KIND_LAST, 64'h0000_0000_0000_0001, NO_BITS, 7'd0);
    send_item(KIND_EXTRACT, 64'hdead_beef_f00d_cafe, ALL_ONES, 7'd0);
    send_item(KIND_DEPOSIT, ALL_ONES, 64'haaaa_aaaa_aaaa_aaaa, 7'd0);
    send_item(KIND_W'(31), ALL_ONES, ALL_ONES, 7'd127);

    // random items, with one pause until the block is empty
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      send_item(random_kind(), random_set(), random_set(), random_amount());
    end

    // let the pipeline empty out, then give the verdict
    drain_results();
    repeat (4) @(negedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ bitset_word_operation_unit.f @@
+incdir+design
design/bwou_pkg.sv
design/bwou_prefix.sv
design/bwou_compress.sv
design/bwou_core.sv
design/bitset_word_operation_unit.sv
design/bwou_checker.sv
sim/bitset_word_operation_unit_check.sv
sim/tb_bitset_word_operation_unit.sv
